>>> rtl/status_led_mode_controller_core_macros.svh
// Assertion macros used by the status LED controller RTL.
`ifndef STATUS_LED_MODE_CONTROLLER_CORE_MACROS_SVH
`define STATUS_LED_MODE_CONTROLLER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Assert that a property holds on every clock edge outside reset.
`define SLMC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert that a condition implies a consequence in the same cycle.
`define SLMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Assert that a condition implies a consequence in the next cycle.
`define SLMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SLMC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SLMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SLMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/slmc_pkg.sv
// Types, codes and helper functions of the status LED controller.
`default_nettype none
package slmc_pkg;

  // Item opcodes.
  localparam logic OP_MODE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Mode codes.
  localparam logic [2:0] MODE_OFF        = 3'd0;
  localparam logic [2:0] MODE_AP         = 3'd1;
  localparam logic [2:0] MODE_CONNECTING = 3'd2;
  localparam logic [2:0] MODE_CONNECTED  = 3'd3;
  localparam logic [2:0] MODE_LINK_OK    = 3'd4;
  localparam logic [2:0] MODE_OTA        = 3'd5;
  localparam logic [2:0] MODE_ERROR      = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LED_PRESENT   = 2'd0;
  localparam logic [1:0] CFG_STEP_INTERVAL = 2'd1;
  localparam logic [1:0] CFG_HOLD_TIME     = 2'd2;

  // Configuration reset values.
  localparam logic        LED_PRESENT_RST   = 1'b1;
  localparam logic [7:0]  STEP_INTERVAL_RST = 8'd8;
  localparam logic [31:0] HOLD_TIME_RST     = 32'd120000;

  // Solid colors, red/green/blue.
  localparam logic [7:0] AP_R = 8'd8,   AP_G = 8'd0,   AP_B = 8'd8;
  localparam logic [7:0] LINK_R = 8'd12, LINK_G = 8'd10, LINK_B = 8'd0;
  localparam logic [7:0] OTA_R = 8'd0,  OTA_G = 8'd12, OTA_B = 8'd12;
  localparam logic [7:0] ERR_R = 8'd20, ERR_G = 8'd0,  ERR_B = 8'd0;

  // Pulse level offset.
  localparam logic [7:0] PULSE_BASE = 8'd3;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  mode_request;
    logic [31:0] now_ms;
  } slmc_item_t;

  typedef struct packed {
    logic       color_valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } slmc_result_t;

  // Triangle wave level: (tri / 10) + 3. The divide by ten is a multiply by
  // 205 / 2048, which is exact for every triangle value up to 254.
  function automatic logic [7:0] tri_level(input logic [7:0] ph);
    logic [7:0]  t;
    logic [15:0] prod;
    begin
      t    = ph[7] ? {~ph[6:0], 1'b0} : {ph[6:0], 1'b0};
      prod = 16'(t) * 16'd205;
      tri_level = 8'(prod[15:11]) + PULSE_BASE;
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/slmc_if.sv
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none
interface slmc_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [2:0]  mode_request;
  logic [31:0] now_ms;

  modport source (output valid, output opcode, output mode_request, output now_ms,
                  input ready);
  modport sink   (input valid, input opcode, input mode_request, input now_ms,
                  output ready);
endinterface

interface slmc_out_if;
  logic       valid;
  logic       ready;
  logic       color_valid;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output color_valid, output red, output green,
                  output blue, input ready);
  modport sink   (input valid, input color_valid, input red, input green,
                  input blue, output ready);
endinterface
`default_nettype wire

>>> rtl/slmc_in_stage.sv
// Input register stage that captures one item per cycle while it is empty or its item moves on.
`default_nettype none
module slmc_in_stage
  import slmc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire slmc_item_t in_item,
  input  wire logic       take,
  output logic            item_valid,
  output slmc_item_t      item
);

  logic       valid_r;
  logic       valid_nxt;
  slmc_item_t item_r;

  // The stage takes a new item when empty or when its item moves on.
  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_valid ? 1'b1 : (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload has no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

>>> rtl/slmc_engine.sv
// Mode state, configuration registers, color logic and result register.
`default_nettype none
`include "status_led_mode_controller_core_macros.svh"
module slmc_engine
  import slmc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata,
  input  wire logic         item_valid,
  input  wire slmc_item_t   item,
  output logic              take,
  output logic              out_valid,
  input  wire logic         out_ready,
  output slmc_result_t      out_result
);

  // Configuration registers.
  logic        led_present_r;
  logic [7:0]  step_interval_r;
  logic [31:0] hold_time_r;

  // Mode state.
  logic [2:0]  mode_r, mode_nxt;
  logic [31:0] last_update_r, last_update_nxt;
  logic [31:0] enter_r, enter_nxt;
  logic [7:0]  phase_r, phase_nxt;
  logic        expired_r, expired_nxt;

  // Result register.
  logic         out_valid_r;
  slmc_result_t result_r, result_nxt;

  logic [31:0] dt;
  logic [31:0] held;
  logic [7:0]  phase_inc;
  logic [7:0]  level;
  logic        pulse_due;

  // An item moves into the result register when that register is free.
  assign take = item_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_present_r   <= LED_PRESENT_RST;
      step_interval_r <= STEP_INTERVAL_RST;
      hold_time_r     <= HOLD_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LED_PRESENT:   led_present_r   <= cfg_wdata[0];
        CFG_STEP_INTERVAL: step_interval_r <= cfg_wdata[7:0];
        CFG_HOLD_TIME:     hold_time_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Shared arithmetic for the tick path.
  assign dt        = item.now_ms - last_update_r;
  assign held      = item.now_ms - enter_r;
  assign phase_inc = phase_r + 8'd1;
  assign level     = tri_level(phase_inc);
  assign pulse_due = dt > 32'(step_interval_r);

  // Next state and result for the item in the input register.
  always_comb begin
    mode_nxt        = mode_r;
    last_update_nxt = last_update_r;
    enter_nxt       = enter_r;
    phase_nxt       = phase_r;
    expired_nxt     = expired_r;
    result_nxt      = '0;
    if (item.opcode == OP_MODE) begin
      if (item.mode_request <= MODE_ERROR) begin
        if (item.mode_request == MODE_CONNECTING || item.mode_request == MODE_AP) begin
          expired_nxt = 1'b0;
        end
        if (!(item.mode_request == MODE_LINK_OK && expired_r) &&
            item.mode_request != mode_r) begin
          mode_nxt        = item.mode_request;
          last_update_nxt = '0;
          enter_nxt       = item.now_ms;
          phase_nxt       = '0;
        end
      end
    end else if (led_present_r) begin
      case (mode_r)
        MODE_OFF: begin
          result_nxt      = '{1'b1, 8'd0, 8'd0, 8'd0};
          last_update_nxt = item.now_ms;
        end
        MODE_AP: begin
          result_nxt      = '{1'b1, AP_R, AP_G, AP_B};
          last_update_nxt = item.now_ms;
        end
        MODE_CONNECTING: begin
          if (pulse_due) begin
            phase_nxt       = phase_inc;
            result_nxt      = '{1'b1, 8'd0, 8'd0, level};
            last_update_nxt = item.now_ms;
          end
        end
        MODE_CONNECTED: begin
          if (pulse_due) begin
            phase_nxt       = phase_inc;
            result_nxt      = '{1'b1, 8'd0, level, 8'd0};
            last_update_nxt = item.now_ms;
          end
        end
        MODE_LINK_OK: begin
          if (held > hold_time_r) begin
            expired_nxt = 1'b1;
            mode_nxt    = MODE_OFF;
            result_nxt  = '{1'b1, 8'd0, 8'd0, 8'd0};
          end else begin
            result_nxt  = '{1'b1, LINK_R, LINK_G, LINK_B};
          end
          last_update_nxt = item.now_ms;
        end
        MODE_OTA: begin
          result_nxt      = '{1'b1, OTA_R, OTA_G, OTA_B};
          last_update_nxt = item.now_ms;
        end
        MODE_ERROR: begin
          result_nxt      = '{1'b1, ERR_R, ERR_G, ERR_B};
          last_update_nxt = item.now_ms;
        end
        default: ;
      endcase
    end
  end

  // State advances with each item that reaches the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_OFF;
      last_update_r <= '0;
      enter_r       <= '0;
      phase_r       <= '0;
      expired_r     <= 1'b0;
    end else if (take) begin
      mode_r        <= mode_nxt;
      last_update_r <= last_update_nxt;
      enter_r       <= enter_nxt;
      phase_r       <= phase_nxt;
      expired_r     <= expired_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

  // A result without a color carries black.
  `SLMC_ASSERT_IMP(a_black_when_idle, clk, rst_n, out_valid_r && !result_r.color_valid, result_r.red == 8'd0 && result_r.green == 8'd0 && result_r.blue == 8'd0, "undriven result is not black")
  // Once the hold window has expired, link-ok cannot be the current mode.
  `SLMC_ASSERT(a_expired_not_link, clk, rst_n, !(expired_r && mode_r == MODE_LINK_OK), "link-ok active after expiry")
  // The pulse phase moves only in the two pulse modes.
  `SLMC_ASSERT_IMP(a_phase_in_pulse, clk, rst_n, phase_r != 8'd0, mode_r == MODE_CONNECTING || mode_r == MODE_CONNECTED, "pulse phase set outside a pulse mode")
  // Every item taken shows up as a pending result.
  `SLMC_ASSERT_NXT(a_take_loads, clk, rst_n, take, out_valid_r, "taken item produced no result")

endmodule
`default_nettype wire

>>> rtl/status_led_mode_controller_core.sv
// Top level of the status LED mode controller.
//
//   Channel  Dir  Handshake       Payload
//   in_ch    in   valid/ready     opcode, mode_request, now_ms
//   out_ch   out  valid/ready     color_valid, red, green, blue
//   cfg      in   cfg_we          cfg_index, cfg_wdata
//
// Every item gives one result: it waits in the input register, then the mode
// and color logic loads the result register. One item per cycle is sustained
// while the receiver is ready; the mode state updates as each result loads.
// Reset is synchronous, active low, and restores mode off and the register
// defaults. A stalled result holds the result register, and the input register
// keeps accepting until it is full.
`default_nettype none
module status_led_mode_controller_core
  import slmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  slmc_in_if.sink          in_ch,
  slmc_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  slmc_item_t   in_item;
  slmc_item_t   stage_item;
  slmc_result_t result;
  logic         stage_valid;
  logic         take;
  logic         in_ready;
  logic         out_valid;

  // Gather the input payload.
  assign in_item.opcode       = in_ch.opcode;
  assign in_item.mode_request = in_ch.mode_request;
  assign in_item.now_ms       = in_ch.now_ms;
  assign in_ch.ready          = in_ready;

  slmc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (stage_valid),
    .item       (stage_item)
  );

  slmc_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .item_valid (stage_valid),
    .item       (stage_item),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .out_result (result)
  );

  // Drive the result channel.
  assign out_ch.valid       = out_valid;
  assign out_ch.color_valid = result.color_valid;
  assign out_ch.red         = result.red;
  assign out_ch.green       = result.green;
  assign out_ch.blue        = result.blue;

endmodule
`default_nettype wire

>>> test/status_led_mode_controller_core_test.sv
// Self-checking testbench for the status LED mode controller core.
`default_nettype none
module status_led_mode_controller_core_test;
  import slmc_pkg::*;

  // Mode code that no mode uses; the block must ignore requests for it.
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  // Idle cycles waited after the last expected result has drained.
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 400000;
  // Mismatch lines beyond this count are counted but not printed.
  localparam int REPORT_LINES = 40;

  typedef struct {
    slmc_item_t   item;
    bit           typed;
    slmc_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  slmc_in_if  in_ch();
  slmc_out_if out_ch();

  status_led_mode_controller_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register copies held by the predictor.
  logic        led_on  = LED_PRESENT_RST;
  logic [7:0]  step_ms = STEP_INTERVAL_RST;
  logic [31:0] hold_ms = HOLD_TIME_RST;

  // Mode state held by the predictor.
  logic [2:0]  cur_mode     = MODE_OFF;
  logic [31:0] last_upd     = '0;
  logic [31:0] enter_ms     = '0;
  logic [7:0]  phase        = '0;
  logic        link_expired = 1'b0;

  slmc_result_t expected_colors[$];
  stim_row_t    dir_rows[$];
  slmc_result_t want;
  logic [31:0]  sim_now;
  int           mismatches = 0;
  int           cycle_count = 0;
  int           burst_left = 1;
  bit           valid_on = 1'b0;
  logic [7:0]   ready_pat = 8'hFF;
  logic [2:0]   ready_pos = '0;
  logic [5:0]   ready_age = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a run that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL status_led_mode_controller_core");
      $finish;
    end
  end

  function automatic slmc_result_t rgb(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    slmc_result_t c;
    c.color_valid = 1'b1;
    c.red         = r;
    c.green       = g;
    c.blue        = b;
    return c;
  endfunction

  // Triangle wave over the 8-bit phase, scaled down by ten and offset by three.
  function automatic logic [7:0] pulse_level(input logic [7:0] ph);
    logic [7:0] t;
    t = (ph < 8'd128) ? ph * 8'd2 : (8'd255 - ph) * 8'd2;
    return t / 8'd10 + 8'd3;
  endfunction

  // Works out the result of one item and advances the predicted state.
  function automatic slmc_result_t predict_led_color(input slmc_item_t it);
    slmc_result_t c;
    logic [31:0]  since_upd;
    logic [31:0]  since_enter;
    logic [7:0]   lvl;
    c = '0;
    if (it.opcode == OP_MODE) begin
      if (it.mode_request != MODE_UNUSED) begin
        if (it.mode_request == MODE_CONNECTING || it.mode_request == MODE_AP)
          link_expired = 1'b0;
        if (!(it.mode_request == MODE_LINK_OK && link_expired) &&
            it.mode_request != cur_mode) begin
          cur_mode = it.mode_request;
          last_upd = '0;
          enter_ms = it.now_ms;
          phase    = '0;
        end
      end
    end else if (led_on) begin
      since_upd   = it.now_ms - last_upd;
      since_enter = it.now_ms - enter_ms;
      case (cur_mode)
        MODE_OFF: begin
          c = rgb(8'd0, 8'd0, 8'd0);
          last_upd = it.now_ms;
        end
        MODE_AP: begin
          c = rgb(AP_R, AP_G, AP_B);
          last_upd = it.now_ms;
        end
        MODE_CONNECTING, MODE_CONNECTED: begin
          // The pulse steps only once more than the interval has passed.
          if (since_upd > {24'd0, step_ms}) begin
            phase = phase + 8'd1;
            lvl   = pulse_level(phase);
            c = (cur_mode == MODE_CONNECTING) ? rgb(8'd0, 8'd0, lvl) : rgb(8'd0, lvl, 8'd0);
            last_upd = it.now_ms;
          end
        end
        MODE_LINK_OK: begin
          if (since_enter > hold_ms) begin
            link_expired = 1'b1;
            cur_mode     = MODE_OFF;
            c = rgb(8'd0, 8'd0, 8'd0);
          end else begin
            c = rgb(LINK_R, LINK_G, LINK_B);
          end
          last_upd = it.now_ms;
        end
        MODE_OTA: begin
          c = rgb(OTA_R, OTA_G, OTA_B);
          last_upd = it.now_ms;
        end
        MODE_ERROR: begin
          c = rgb(ERR_R, ERR_G, ERR_B);
          last_upd = it.now_ms;
        end
        default: begin
        end
      endcase
    end
    return c;
  endfunction

  function automatic stim_row_t row(input logic op, input logic [2:0] md,
                                    input logic [31:0] now, input bit typed,
                                    input logic cv, input logic [7:0] r,
                                    input logic [7:0] g, input logic [7:0] b);
    stim_row_t s;
    s.item.opcode       = op;
    s.item.mode_request = md;
    s.item.now_ms       = now;
    s.typed             = typed;
    s.want.color_valid  = cv;
    s.want.red          = r;
    s.want.green        = g;
    s.want.blue         = b;
    return s;
  endfunction

  // Random item: time mostly moves forward by pulse-sized or hold-sized steps,
  // with the odd jump anywhere; link-ok requests are favored.
  function automatic slmc_item_t random_item();
    slmc_item_t it;
    case ($urandom_range(0, 9))
      0: sim_now = $urandom;
      1, 2: sim_now = sim_now + $urandom_range(hold_ms - (hold_ms >> 3), hold_ms) +
                      $urandom_range(0, 2);
      default: sim_now = sim_now + $urandom_range(0, 2 * int'(step_ms) + 2);
    endcase
    it.now_ms = sim_now;
    if ($urandom_range(0, 3) == 0) begin
      it.opcode       = OP_MODE;
      it.mode_request = ($urandom_range(0, 2) == 0) ? MODE_LINK_OK : 3'($urandom_range(0, 7));
    end else begin
      it.opcode       = OP_TICK;
      it.mode_request = 3'($urandom);
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (mismatches < REPORT_LINES)
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, exp_val);
    mismatches++;
  endtask

  // Sends one item in bursts with random gaps and queues its expected result.
  task automatic send_item(input slmc_item_t it, input bit typed, input slmc_result_t typed_want);
    slmc_result_t pred;
    pred = predict_led_color(it);
    expected_colors.push_back(typed ? typed_want : pred);
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= it.opcode;
    in_ch.mode_request <= it.mode_request;
    in_ch.now_ms       <= it.now_ms;
    valid_on = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      valid_on = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
  endtask

  // Lets every outstanding item drain so the block is idle.
  task automatic settle();
    if (valid_on) begin
      in_ch.valid <= 1'b0;
      valid_on = 1'b0;
    end
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Writes all three registers; bits above each register's width are junk.
  task automatic apply_settings(input logic led, input logic [7:0] step,
                                input logic [31:0] hold);
    write_reg(CFG_LED_PRESENT, (32'($urandom) & ~32'd1) | {31'd0, led});
    write_reg(CFG_STEP_INTERVAL, (32'($urandom) & ~32'hFF) | {24'd0, step});
    write_reg(CFG_HOLD_TIME, hold);
    cfg_we  <= 1'b0;
    led_on  = led;
    step_ms = step;
    hold_ms = hold;
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_item(random_item(), 1'b0, '0);
  endtask

  // Receiver ready follows a repeating 8-bit pattern that is redrawn whenever the 6-bit age counter wraps.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (ready_age == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pat = 8'hFF;
          1: ready_pat = 8'($urandom);
          2: ready_pat = 8'h01;
          default: ready_pat = 8'hF0;
        endcase
      end
      out_ch.ready <= ready_pat[ready_pos];
      ready_pos = ready_pos + 3'd1;
      ready_age = ready_age + 6'd1;
    end
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_colors.size() == 0) begin
        report_mismatch("result with nothing expected, color_valid", 32'(out_ch.color_valid),
                        32'd0);
      end else begin
        want = expected_colors.pop_front();
        if (out_ch.color_valid !== want.color_valid)
          report_mismatch("color_valid", 32'(out_ch.color_valid), 32'(want.color_valid));
        if (out_ch.red !== want.red)
          report_mismatch("red", 32'(out_ch.red), 32'(want.red));
        if (out_ch.green !== want.green)
          report_mismatch("green", 32'(out_ch.green), 32'(want.green));
        if (out_ch.blue !== want.blue)
          report_mismatch("blue", 32'(out_ch.blue), 32'(want.blue));
      end
    end
  end

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_LED_PRESENT;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OP_MODE;
    in_ch.mode_request <= MODE_OFF;
    in_ch.now_ms       <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items, run with the reset register values.
    dir_rows.push_back(row(OP_TICK, MODE_OFF, 32'd0, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0));
    dir_rows.push_back(row(OP_MODE, MODE_UNUSED, 32'd5, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0));
    dir_rows.push_back(row(OP_MODE, MODE_AP, 32'd10, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0));
    dir_rows.push_back(row(OP_TICK, MODE_UNUSED, 32'd11, 1'b1, 1'b1, 8'd8, 8'd0, 8'd8));
    dir_rows.push_back(row(OP_MODE, MODE_AP, 32'd12, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0));
    dir_rows.push_back(row(OP_MODE, MODE_CONNECTING, 32'd100, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0));
    dir_rows.push_back(row(OP_TICK, MODE_OFF, 32'd100, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0));
    dir_rows.push_back(row(OP_TICK, MODE_OFF, 32'd105, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0));
    // Exactly the interval since the last step is not enough.
    dir_rows.push_back(row(OP_TICK, MODE_OFF, 32'd108, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0));
    dir_rows.push_back(row(OP_TICK, MODE_OFF, 32'd109, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0));
    dir_rows.push_back(row(OP_MODE, MODE_CONNECTED, 32'd200, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0));
    dir_rows.push_back(row(OP_TICK, MODE_OFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0));
    // Time wraps: one millisecond has passed, so the pulse is not due.
    dir_rows.push_back(row(OP_TICK, MODE_OFF, 32'd0, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0));
    dir_rows.push_back(row(OP_MODE, MODE_OTA, 32'd300, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0));
    dir_rows.push_back(row(OP_TICK, MODE_OFF, 32'd301, 1'b1, 1'b1, 8'd0, 8'd12, 8'd12));
    dir_rows.push_back(row(OP_MODE, MODE_ERROR, 32'd400, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0));
    dir_rows.push_back(row(OP_TICK, MODE_OFF, 32'd401, 1'b1, 1'b1, 8'd20, 8'd0, 8'd0));
    // Link-ok holds yellow to the end of the window, then expires to black.
    dir_rows.push_back(row(OP_MODE, MODE_LINK_OK, 32'd1000, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0));
    dir_rows.push_back(row(OP_TICK, MODE_OFF, 32'd121000, 1'b1, 1'b1, 8'd12, 8'd10, 8'd0));
    dir_rows.push_back(row(OP_TICK, MODE_OFF, 32'd121001, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0));
    // A link-ok request after expiry is refused, so the mode stays off.
    dir_rows.push_back(row(OP_MODE, MODE_LINK_OK, 32'd121002, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0));
    dir_rows.push_back(row(OP_TICK, MODE_OFF, 32'd121003, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0));
    // Connecting clears the expiry; the hold window then spans the time wrap.
    dir_rows.push_back(row(OP_MODE, MODE_CONNECTING, 32'h8000_0000, 1'b1, 1'b0,
                           8'd0, 8'd0, 8'd0));
    dir_rows.push_back(row(OP_MODE, MODE_LINK_OK, 32'hFFFF_FFF0, 1'b1, 1'b0,
                           8'd0, 8'd0, 8'd0));
    dir_rows.push_back(row(OP_TICK, MODE_OFF, 32'h0000_FFFF, 1'b1, 1'b1, 8'd12, 8'd10, 8'd0));
    dir_rows.push_back(row(OP_MODE, MODE_OFF, 32'h0001_0000, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0));
    dir_rows.push_back(row(OP_TICK, MODE_OFF, 32'h0001_0001, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0));
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // Random phases under several register settings.
    sim_now = 32'h0002_0000;
    settle();
    apply_settings(1'b1, 8'd0, 32'd0);
    run_random(300);

    // A long pulse run so the phase wraps past 255; every tick is due.
    settle();
    apply_settings(1'b1, 8'd0, HOLD_TIME_RST);
    send_item('{opcode: OP_MODE, mode_request: MODE_CONNECTING, now_ms: sim_now}, 1'b0, '0);
    for (int i = 0; i < 300; i++) begin
      sim_now = sim_now + $urandom_range(1, 3);
      send_item('{opcode: OP_TICK, mode_request: 3'($urandom), now_ms: sim_now}, 1'b0, '0);
    end

    settle();
    apply_settings(1'b1, 8'd255, 32'hFFFF_FFFF);
    run_random(300);

    settle();
    apply_settings(1'b0, 8'($urandom), $urandom);
    run_random(250);

    settle();
    apply_settings(1'b1, 8'($urandom_range(0, 20)), $urandom_range(0, 3000));
    run_random(350);

    settle();
    apply_settings(LED_PRESENT_RST, STEP_INTERVAL_RST, HOLD_TIME_RST);
    run_random(300);

    settle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_colors.size() == 0) begin
      $display("PASS status_led_mode_controller_core");
    end else begin
      $display("FAIL status_led_mode_controller_core");
    end
    $finish;
  end

endmodule
`default_nettype wire
